// ===== rtl/core/shoc_pkg.sv =====
// Shared types, constants and table functions for the seat heater controller.
// Used by shoc_lane, shoc_merge and seat_heater_overtemp_controller.
package shoc_pkg;

  localparam int TABLE_POINTS = 13;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int CNT_W        = $clog2(TABLE_POINTS + 1);
  localparam int TEMP_W       = 6;
  localparam int RES_W        = 16;
  localparam int MS_W         = 32;
  localparam int PROD_W       = 18;
  localparam int STEP_C       = 5;
  localparam int TOP_TEMP_C   = 60;

  // NTC resistance in ohms at each table point, 60 C down to 0 C in 5 C steps
  localparam logic signed [RES_W:0] RES_POINTS [TABLE_POINTS] = '{
    17'sd2996,  17'sd3513,  17'sd4137,  17'sd4891,  17'sd5809,
    17'sd6929,  17'sd8304,  17'sd10000, 17'sd12100, 17'sd14720,
    17'sd18000, 17'sd22130, 17'sd27350
  };

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_TEMP   = 2'd0;
  localparam logic [1:0] CFG_HEAT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_COOL_WAIT  = 2'd2;

  // Item kinds carried on the input tuser bit
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Reset values of the configuration registers
  localparam logic [TEMP_W-1:0] MAX_TEMP_RST   = 6'd55;
  localparam logic [MS_W-1:0]   HEAT_LIMIT_RST = 32'd1200000;
  localparam logic [MS_W-1:0]   COOL_WAIT_RST  = 32'd10000;

  typedef struct packed {
    logic fire;
    logic sample;
  } upd_t;

  typedef struct packed {
    logic              heat_on;
    logic              cooling;
    logic [TEMP_W-1:0] temp_back;
    logic [TEMP_W-1:0] temp_seat;
  } res_t;

  function automatic logic [TEMP_W-1:0] point_temp(input logic [IDX_W-1:0] idx);
    int t;
    t = TOP_TEMP_C - STEP_C * int'(idx);
    return TEMP_W'(t);
  endfunction

  // k times the width of segment seg, the k-th fifth boundary of (r-lo)*5
  function automatic logic [PROD_W-1:0] seg_thr(input logic [IDX_W-1:0] seg,
                                                 input int k);
    logic signed [RES_W+1:0] span;
    int                      nxt;
    nxt  = (int'(seg) + 1 < TABLE_POINTS) ? int'(seg) + 1 : TABLE_POINTS - 1;
    span = RES_POINTS[IDX_W'(nxt)] - RES_POINTS[seg];
    return PROD_W'(k * int'(span));
  endfunction

endpackage

// ===== rtl/core/shoc_lane.sv =====
// One NTC conversion lane: resistance to whole degrees Celsius.
// Two register stages: segment search, then fractional drop. Uses shoc_pkg.
module shoc_lane (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               advance,
  input  logic signed [shoc_pkg::RES_W-1:0]  res,
  output logic        [shoc_pkg::TEMP_W-1:0] temp
);

  logic signed [shoc_pkg::RES_W-1:0]  res_r;
  logic        [shoc_pkg::IDX_W-1:0]  seg_r;
  logic                               lo_clamp_r;
  logic                               hi_clamp_r;
  logic        [shoc_pkg::TEMP_W-1:0] temp_r;

  logic        [shoc_pkg::CNT_W-1:0]  cnt;
  logic signed [shoc_pkg::RES_W:0]    res_x;
  logic signed [shoc_pkg::RES_W:0]    diff;
  logic        [shoc_pkg::PROD_W-1:0] prod;
  logic        [2:0]                  drop;
  logic        [shoc_pkg::TEMP_W-1:0] temp_nxt;

  assign res_x = {res[shoc_pkg::RES_W-1], res};

  // Count table points at or below the resistance
  always_comb begin
    cnt = '0;
    for (int j = 0; j < shoc_pkg::TABLE_POINTS; j++) begin
      if (res_x >= shoc_pkg::RES_POINTS[j]) begin
        cnt = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r      <= res;
      seg_r      <= shoc_pkg::IDX_W'(cnt - 1'b1);
      lo_clamp_r <= (res_x <= shoc_pkg::RES_POINTS[0]);
      hi_clamp_r <= (res_x >= shoc_pkg::RES_POINTS[shoc_pkg::TABLE_POINTS-1]);
    end
  end

  // Drop within a segment: how many fifths of its width (r-lo)*5 reaches
  always_comb begin
    diff = {res_r[shoc_pkg::RES_W-1], res_r} - shoc_pkg::RES_POINTS[seg_r];
    prod = shoc_pkg::PROD_W'(diff[shoc_pkg::RES_W-1:0]) * shoc_pkg::PROD_W'(3'd5);
    drop = '0;
    for (int k = 1; k < shoc_pkg::STEP_C; k++) begin
      if (prod >= shoc_pkg::seg_thr(seg_r, k)) begin
        drop = drop + 1'b1;
      end
    end
    if (lo_clamp_r) begin
      temp_nxt = shoc_pkg::point_temp('0);
    end else if (hi_clamp_r) begin
      temp_nxt = shoc_pkg::point_temp(shoc_pkg::IDX_W'(shoc_pkg::TABLE_POINTS - 1));
    end else begin
      temp_nxt = shoc_pkg::point_temp(seg_r) - shoc_pkg::TEMP_W'(drop);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      temp_r <= temp_nxt;
    end
  end

  assign temp = temp_r;

endmodule

// ===== rtl/core/shoc_merge.sv =====
// Merge stage: combines both lane temperatures with the heating timeout,
// over-temperature and resume rules. Holds the controller state. Uses shoc_pkg.
module shoc_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  shoc_pkg::upd_t                     upd,
  input  logic        [shoc_pkg::TEMP_W-1:0] lane_back,
  input  logic        [shoc_pkg::TEMP_W-1:0] lane_seat,
  input  logic        [shoc_pkg::TEMP_W-1:0] max_temp,
  input  logic        [shoc_pkg::MS_W-1:0]   heat_limit,
  input  logic        [shoc_pkg::MS_W-1:0]   cool_wait,
  output shoc_pkg::res_t                     res_nxt
);

  logic                        heating_r,   heating_nxt;
  logic                        cool_r,      cool_nxt;
  logic [shoc_pkg::MS_W-1:0]   ms_r,        ms_nxt;
  logic [shoc_pkg::MS_W-1:0]   cstart_r,    cstart_nxt;
  logic [shoc_pkg::TEMP_W-1:0] back_r,      back_nxt;
  logic [shoc_pkg::TEMP_W-1:0] seat_r,      seat_nxt;

  always_comb begin
    heating_nxt = heating_r;
    cool_nxt    = cool_r;
    ms_nxt      = ms_r;
    cstart_nxt  = cstart_r;
    back_nxt    = back_r;
    seat_nxt    = seat_r;
    if (!upd.sample) begin
      ms_nxt = ms_r + 1'b1;
    end else begin
      back_nxt = lane_back;
      seat_nxt = lane_seat;
      if (heating_nxt && (ms_nxt > heat_limit)) begin
        heating_nxt = 1'b0;
        ms_nxt      = '0;
      end
      if (heating_nxt && ((lane_back > max_temp) || (lane_seat > max_temp))) begin
        cstart_nxt  = ms_nxt;
        heating_nxt = 1'b0;
        cool_nxt    = 1'b1;
      end
      if (!heating_nxt && cool_nxt && (ms_nxt > (cstart_nxt + cool_wait))) begin
        heating_nxt = 1'b1;
        cool_nxt    = 1'b0;
        cstart_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heating_r <= 1'b1;
      cool_r    <= 1'b0;
      ms_r      <= '0;
      cstart_r  <= '0;
      back_r    <= '0;
      seat_r    <= '0;
    end else if (upd.fire) begin
      heating_r <= heating_nxt;
      cool_r    <= cool_nxt;
      ms_r      <= ms_nxt;
      cstart_r  <= cstart_nxt;
      back_r    <= back_nxt;
      seat_r    <= seat_nxt;
    end
  end

  assign res_nxt.heat_on   = heating_nxt;
  assign res_nxt.cooling   = cool_nxt;
  assign res_nxt.temp_back = back_nxt;
  assign res_nxt.temp_seat = seat_nxt;

endmodule

// ===== rtl/core/seat_heater_overtemp_controller.sv =====
// Seat heater over-temperature controller: two NTC lanes and a rule merge stage.
// A tick beat goes from the wait state straight to the merge update; a sample beat
// first passes lane search and lane drop. out_tvalid is registered from the merge
// update, and a waiting result holds the merge update. One item in flight at a time.
// Reset (rst_n, synchronous, active low): heating on, cooldown off, counters
// and temperatures zero, registers at their defaults, no result pending.
module seat_heater_overtemp_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] res_back, [31:16] res_seat
  input  logic [0:0]  in_tuser,   // [0] cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] heat_on, [1] cooling, [7:2] temp_back,
                                  // [13:8] temp_seat, [15:14] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // One-hot sequencer: wait, lane segment stage, lane drop stage, merge update
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SEG   = 4'b0010,
    S_DROP  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [shoc_pkg::TEMP_W-1:0] max_temp_r;
  logic [shoc_pkg::MS_W-1:0]   heat_limit_r;
  logic [shoc_pkg::MS_W-1:0]   cool_wait_r;

  logic                        sample_r;
  logic                        out_valid_r;
  shoc_pkg::res_t              out_res_r;

  logic                        in_fire;
  logic                        apply_go;
  shoc_pkg::upd_t              upd;
  shoc_pkg::res_t              res_nxt;
  logic [shoc_pkg::TEMP_W-1:0] lane_back;
  logic [shoc_pkg::TEMP_W-1:0] lane_seat;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // Hold the merge update while the previous result still waits
  assign apply_go  = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  // Configuration registers; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_temp_r   <= shoc_pkg::MAX_TEMP_RST;
      heat_limit_r <= shoc_pkg::HEAT_LIMIT_RST;
      cool_wait_r  <= shoc_pkg::COOL_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        shoc_pkg::CFG_MAX_TEMP:   max_temp_r   <= cfg_wdata[shoc_pkg::TEMP_W-1:0];
        shoc_pkg::CFG_HEAT_LIMIT: heat_limit_r <= cfg_wdata;
        shoc_pkg::CFG_COOL_WAIT:  cool_wait_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser[0] == shoc_pkg::CMD_SAMPLE) ? S_SEG : S_APPLY;
        end
      end
      S_SEG:   state_nxt = S_DROP;
      S_DROP:  state_nxt = S_APPLY;
      S_APPLY: begin
        if (apply_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sample_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        sample_r <= (in_tuser[0] == shoc_pkg::CMD_SAMPLE);
      end
    end
  end

  // Both lanes load their segment stage on every accepted beat, sample or tick
  shoc_lane u_lane_back (
    .clk     (clk),
    .load    (in_fire),
    .advance (state_r == S_SEG),
    .res     (in_tdata[15:0]),
    .temp    (lane_back)
  );

  shoc_lane u_lane_seat (
    .clk     (clk),
    .load    (in_fire),
    .advance (state_r == S_SEG),
    .res     (in_tdata[31:16]),
    .temp    (lane_seat)
  );

  assign upd.fire   = apply_go;
  assign upd.sample = sample_r;

  shoc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .lane_back  (lane_back),
    .lane_seat  (lane_seat),
    .max_temp   (max_temp_r),
    .heat_limit (heat_limit_r),
    .cool_wait  (cool_wait_r),
    .res_nxt    (res_nxt)
  );

  // Output register: capture the result on the merge update, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.temp_seat, out_res_r.temp_back,
                       out_res_r.cooling, out_res_r.heat_on};

`ifndef SYNTHESIS
  // Heating and cooldown are never reported together
  a_heat_xor_cool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.heat_on && out_res_r.cooling))
    else $error("heat_on and cooling both set");

  // Converted temperatures stay within the table range
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.temp_back <= 6'd60) && (out_res_r.temp_seat <= 6'd60))
    else $error("temperature out of range");

  // A new result only follows a merge update
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result without merge update");
`endif

endmodule
